// ===== src/cicb_pkg.sv =====
// shared types, constants and helpers for the clamped-border convolution engine
`default_nettype none

package cicb_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] OpLoadWeight = 2'd0;
   localparam logic [1:0] OpWritePixel = 2'd1;
   localparam logic [1:0] OpCompute    = 2'd2;

   // register indexes on the csr channel
   localparam logic [2:0] CsrImageWidth   = 3'd0;
   localparam logic [2:0] CsrImageHeight  = 3'd1;
   localparam logic [2:0] CsrKernelWidth  = 3'd2;
   localparam logic [2:0] CsrKernelHeight = 3'd3;
   localparam logic [2:0] CsrChannelCount = 3'd4;

   // field widths
   localparam int SampleBits   = 8;
   localparam int Lanes        = 4;
   localparam int CoordBits    = 9;
   localparam int KernBits     = 3;
   localparam int TapBits      = 6;
   localparam int WeightBits   = 16;
   localparam int WordBits     = SampleBits * Lanes;
   localparam int ProdBits     = 24;
   localparam int AccBits      = 31;
   localparam int ReqDataBits  = 72;
   localparam int ReqUserBits  = 2;
   localparam int RspDataBits  = 32;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 9;

   // control that travels with one tap through the read and multiply stages
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tap_ctl_type;

   // clamp a window coordinate (two's complement, 11 bits) into 0..size-1
   function automatic logic [CoordBits-1:0] clamp_coord(input logic [10:0] raw,
                                                        input logic [CoordBits-1:0] size);
      logic [CoordBits-1:0] res;
      if (raw[10]) begin
         res = '0;
      end else if (raw[9:0] >= {1'b0, size}) begin
         res = size - CoordBits'(1);
      end else begin
         res = raw[CoordBits-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/image_convolution_clamped_border.sv =====
// A 2D convolution engine with replicate border. Three kinds of item arrive on the req
// channel (req_tuser): load one kernel weight, write one pixel into the frame store, or
// compute the filtered pixel at a column and row. Loads and writes give no result. A
// compute item reads one frame-store word and one weight per kernel tap, one tap per
// cycle, as the frame store has a single read port; its result passes the read,
// multiply and accumulate registers into the rsp output register, and no new item is
// taken until the result has been loaded there. While a result waits on rsp, further
// items are taken; a second compute stalls at its end until the output register is free.
// Neighbour coordinates are clamped to the image edge. Weights are signed with
// WEIGHT_FRAC_BITS fraction bits; channel sums are truncated toward zero and saturated to
// 0..255. Neither store is cleared after reset: reading a pixel or weight that was never
// written gives an undefined result. The csr channel is always ready and must be written
// only while the engine is idle.
`default_nettype none

module image_convolution_clamped_border #(
   parameter int MAX_WIDTH        = 256,
   parameter int MAX_HEIGHT       = 256,
   parameter int MAX_KERNEL       = 7,
   parameter int MAX_CHANNELS     = 4,
   parameter int WEIGHT_FRAC_BITS = 12
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request items
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [7:0] pixel_col, [15:8] pixel_row, [21:16] tap_index, [37:22] tap_weight,
   // [45:38] sample_ch0, [53:46] sample_ch1, [61:54] sample_ch2, [69:62] sample_ch3
   input  wire logic [cicb_pkg::ReqDataBits-1:0]      req_tdata,
   // [1:0] op
   input  wire logic [cicb_pkg::ReqUserBits-1:0]      req_tuser,
   // result items
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [7:0] result_ch0, [15:8] result_ch1, [23:16] result_ch2, [31:24] result_ch3
   output logic      [cicb_pkg::RspDataBits-1:0]      rsp_tdata,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cicb_pkg::CsrIndexBits-1:0]     csr_index,
   input  wire logic [cicb_pkg::CsrDataBits-1:0]      csr_data
);
   import cicb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   state_type               state_ff;
   logic [CoordBits-1:0]    img_w_ff;
   logic [CoordBits-1:0]    img_h_ff;
   logic [KernBits-1:0]     kern_w_ff;
   logic [KernBits-1:0]     kern_h_ff;
   logic [KernBits-1:0]     chan_ff;
   logic [SampleBits-1:0]   col_ff;
   logic [SampleBits-1:0]   row_ff;
   logic [KernBits-1:0]     kx_ff;
   logic [KernBits-1:0]     ky_ff;
   logic [TapBits-1:0]      tap_ff;
   logic                    rsp_valid_ff;
   logic [RspDataBits-1:0]  rsp_data_ff;

   logic [CoordBits-1:0]    w_eff;
   logic [CoordBits-1:0]    h_eff;
   logic [KernBits-1:0]     kw_eff;
   logic [KernBits-1:0]     kh_eff;
   logic [KernBits-1:0]     nch_eff;
   logic                    req_accept;
   logic                    kx_last;
   logic                    ky_last;
   logic                    rsp_free;
   logic                    rsp_load;
   logic [10:0]             x_raw;
   logic [10:0]             y_raw;
   logic [CoordBits-1:0]    x_clamped;
   logic [CoordBits-1:0]    y_clamped;
   tap_ctl_type             issue;
   logic [WordBits-1:0]     rd_word;
   logic [WeightBits-1:0]   rd_weight;
   logic                    acc_done;
   logic [WordBits-1:0]     acc_result;

   // request fields
   logic [SampleBits-1:0]   req_col;
   logic [SampleBits-1:0]   req_row;
   logic [TapBits-1:0]      req_tap;
   logic [WeightBits-1:0]   req_weight;
   logic [WordBits-1:0]     req_word;

   assign req_col    = req_tdata[7:0];
   assign req_row    = req_tdata[15:8];
   assign req_tap    = req_tdata[21:16];
   assign req_weight = req_tdata[37:22];
   assign req_word   = req_tdata[69:38];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= CoordBits'(256);
         img_h_ff  <= CoordBits'(256);
         kern_w_ff <= KernBits'(3);
         kern_h_ff <= KernBits'(3);
         chan_ff   <= KernBits'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrImageWidth:   img_w_ff  <= csr_data;
            CsrImageHeight:  img_h_ff  <= csr_data;
            CsrKernelWidth:  kern_w_ff <= csr_data[KernBits-1:0];
            CsrKernelHeight: kern_h_ff <= csr_data[KernBits-1:0];
            CsrChannelCount: chan_ff   <= csr_data[KernBits-1:0];
            default: ;
         endcase
      end
   end

   // registers saturated into their usable ranges
   always_comb begin
      w_eff   = (img_w_ff == '0) ? CoordBits'(1) :
                (int'(img_w_ff) > MAX_WIDTH) ? CoordBits'(MAX_WIDTH) : img_w_ff;
      h_eff   = (img_h_ff == '0) ? CoordBits'(1) :
                (int'(img_h_ff) > MAX_HEIGHT) ? CoordBits'(MAX_HEIGHT) : img_h_ff;
      kw_eff  = (kern_w_ff == '0) ? KernBits'(1) :
                (int'(kern_w_ff) > MAX_KERNEL) ? KernBits'(MAX_KERNEL) : kern_w_ff;
      kh_eff  = (kern_h_ff == '0) ? KernBits'(1) :
                (int'(kern_h_ff) > MAX_KERNEL) ? KernBits'(MAX_KERNEL) : kern_h_ff;
      nch_eff = (chan_ff == '0) ? KernBits'(1) :
                (int'(chan_ff) > MAX_CHANNELS) ? KernBits'(MAX_CHANNELS) : chan_ff;
   end

   // handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (((state_ff == ST_DRAIN) && acc_done) || (state_ff == ST_HOLD))
                       && rsp_free;

   // window position of the current tap, clamped to the image
   assign kx_last   = (kx_ff == kw_eff - KernBits'(1));
   assign ky_last   = (ky_ff == kh_eff - KernBits'(1));
   assign x_raw     = 11'(col_ff) - 11'(kw_eff >> 1) + 11'(kx_ff);
   assign y_raw     = 11'(row_ff) - 11'(kh_eff >> 1) + 11'(ky_ff);
   assign x_clamped = clamp_coord(x_raw, w_eff);
   assign y_clamped = clamp_coord(y_raw, h_eff);

   assign issue.valid = (state_ff == ST_ISSUE);
   assign issue.first = (kx_ff == '0) && (ky_ff == '0);
   assign issue.last  = kx_last && ky_last;

   // requested coordinate
   always_ff @(posedge clock) begin
      if (req_accept && (req_tuser == OpCompute)) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kx_ff        <= '0;
         ky_ff        <= '0;
         tap_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_tuser == OpCompute)) begin
                  kx_ff    <= '0;
                  ky_ff    <= '0;
                  tap_ff   <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               tap_ff <= tap_ff + TapBits'(1);
               if (kx_last) begin
                  kx_ff <= '0;
                  ky_ff <= ky_ff + KernBits'(1);
                  if (ky_last) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  kx_ff <= kx_ff + KernBits'(1);
               end
            end
            ST_DRAIN: begin
               if (acc_done) begin
                  if (rsp_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= acc_result;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= acc_result;
                  state_ff     <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // pixel memory
   cicb_frame_store #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_frame (
      .clock   (clock),
      .wr_en   (req_accept && (req_tuser == OpWritePixel)),
      .wr_col  (req_col),
      .wr_row  (req_row),
      .wr_word (req_word),
      .rd_en   (issue.valid),
      .rd_x    (x_clamped),
      .rd_y    (y_clamped),
      .rd_word (rd_word)
   );

   // weight memory
   cicb_weight_store #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_weight (
      .clock     (clock),
      .wr_en     (req_accept && (req_tuser == OpLoadWeight)),
      .wr_tap    (req_tap),
      .wr_weight (req_weight),
      .rd_en     (issue.valid),
      .rd_tap    (tap_ff),
      .rd_weight (rd_weight)
   );

   // multiply-accumulate lanes
   cicb_accum #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_accum (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .weight (rd_weight),
      .word   (rd_word),
      .nch    (nch_eff),
      .done   (acc_done),
      .result (acc_result)
   );

endmodule

`default_nettype wire

// ===== src/cicb_frame_store.sv =====
// frame store: one pixel word per address, row * MAX_WIDTH + column
`default_nettype none

module cicb_frame_store #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [cicb_pkg::SampleBits-1:0]          wr_col,
   input  wire logic [cicb_pkg::SampleBits-1:0]          wr_row,
   input  wire logic [cicb_pkg::WordBits-1:0]            wr_word,
   input  wire logic                                     rd_en,
   input  wire logic [cicb_pkg::CoordBits-1:0]           rd_x,
   input  wire logic [cicb_pkg::CoordBits-1:0]           rd_y,
   output logic      [cicb_pkg::WordBits-1:0]            rd_word
);
   import cicb_pkg::*;

   localparam int Depth     = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrBits  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int StoreBits = SampleBits * MAX_CHANNELS;

   logic [StoreBits-1:0] mem [Depth];
   logic [StoreBits-1:0] rd_word_ff;
   logic [AddrBits-1:0]  wr_addr;
   logic [AddrBits-1:0]  rd_addr;
   logic                 wr_ok;

   // address forming, writes outside the store are dropped
   assign wr_ok   = (int'(wr_col) < MAX_WIDTH) && (int'(wr_row) < MAX_HEIGHT);
   assign wr_addr = AddrBits'(int'(wr_row) * MAX_WIDTH + int'(wr_col));
   assign rd_addr = AddrBits'(int'(rd_y) * MAX_WIDTH + int'(rd_x));

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[wr_addr] <= wr_word[StoreBits-1:0];
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // channels beyond the stored ones read as zero
   assign rd_word = WordBits'(rd_word_ff);

endmodule

`default_nettype wire

// ===== src/cicb_weight_store.sv =====
// kernel weight store, indexed by tap position
`default_nettype none

module cicb_weight_store #(
   parameter int MAX_KERNEL = 7
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [cicb_pkg::TapBits-1:0]       wr_tap,
   input  wire logic [cicb_pkg::WeightBits-1:0]    wr_weight,
   input  wire logic                               rd_en,
   input  wire logic [cicb_pkg::TapBits-1:0]       rd_tap,
   output logic      [cicb_pkg::WeightBits-1:0]    rd_weight
);
   import cicb_pkg::*;

   localparam int Depth    = MAX_KERNEL * MAX_KERNEL;
   localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

   logic [WeightBits-1:0] mem [Depth];
   logic [WeightBits-1:0] rd_weight_ff;
   logic                  wr_ok;

   // loads beyond the kernel area are dropped
   assign wr_ok = int'(wr_tap) < Depth;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[AddrBits'(wr_tap)] <= wr_weight;
      end
      if (rd_en) begin
         rd_weight_ff <= mem[AddrBits'(rd_tap)];
      end
   end

   assign rd_weight = rd_weight_ff;

endmodule

`default_nettype wire

// ===== src/cicb_accum.sv =====
// per-channel multiply, accumulate and final truncate/saturate
`default_nettype none

module cicb_accum #(
   parameter int WEIGHT_FRAC_BITS = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cicb_pkg::tap_ctl_type              issue,
   input  wire logic [cicb_pkg::WeightBits-1:0]    weight,
   input  wire logic [cicb_pkg::WordBits-1:0]      word,
   input  wire logic [cicb_pkg::KernBits-1:0]      nch,
   output logic                                    done,
   output logic      [cicb_pkg::WordBits-1:0]      result
);
   import cicb_pkg::*;

   tap_ctl_type s1_ctl_ff;
   tap_ctl_type s2_ctl_ff;
   logic        done_ff;

   // control follows the memory read and the multiply register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         s1_ctl_ff <= issue;
         s2_ctl_ff <= s1_ctl_ff;
         done_ff   <= s2_ctl_ff.valid && s2_ctl_ff.last;
      end
   end

   assign done = done_ff;

   for (genvar c = 0; c < Lanes; c++) begin : g_lane
      logic signed [ProdBits-1:0] w_ext;
      logic signed [ProdBits-1:0] s_ext;
      logic signed [ProdBits-1:0] prod_ff;
      logic signed [AccBits-1:0]  acc_ff;
      logic signed [AccBits-1:0]  shifted;
      logic [SampleBits-1:0]      res;

      // weight sign-extended, sample zero-extended
      assign w_ext = ProdBits'($signed(weight));
      assign s_ext = $signed(ProdBits'(word[c*SampleBits +: SampleBits]));

      always_ff @(posedge clock) begin
         if (s1_ctl_ff.valid) begin
            prod_ff <= w_ext * s_ext;
         end
         if (s2_ctl_ff.valid) begin
            acc_ff <= s2_ctl_ff.first ? AccBits'(prod_ff) : acc_ff + AccBits'(prod_ff);
         end
      end

      // drop fraction bits, clip to 0..255, unused channels give zero
      assign shifted = acc_ff >>> WEIGHT_FRAC_BITS;

      always_comb begin
         if ((KernBits'(c) >= nch) || (acc_ff <= 0)) begin
            res = '0;
         end else if (shifted > AccBits'(255)) begin
            res = '1;
         end else begin
            res = shifted[SampleBits-1:0];
         end
      end

      assign result[c*SampleBits +: SampleBits] = res;
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the clamped-border convolution engine
`timescale 1ns / 1ps

module tb_top;
   import cicb_pkg::*;

   // codes the package leaves out
   localparam logic [1:0] OpIgnored     = 2'd3;
   localparam logic [2:0] CsrFirstSpare = 3'd5;

   // geometry of the stores and the fixed point format
   localparam int FrameCols = 256;
   localparam int FrameRows = 256;
   localparam int KernMax   = 7;
   localparam int TapSlots  = KernMax * KernMax;
   localparam int FracBits  = 12;
   localparam int PrimeSpan = 8;

   // run shape
   localparam int ItemsPerPhase = 45;
   localparam int DrainCycles   = 64;
   localparam int HoldCycles    = 300;
   localparam int CycleLimit    = 400000;
   localparam int IdlePct       = 58;
   localparam int BothPct       = 23;

   typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

   // one request item, laid out as on req_tdata (samples hold ch0 in the low byte)
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] samples;
      logic [15:0] weight;
      logic [5:0]  tap;
      logic [7:0]  row;
      logic [7:0]  col;
   } conv_item_t;

   typedef struct {
      conv_item_t  item;
      bit          known;
      logic [31:0] known_px;
   } directed_row_t;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataBits-1:0]  req_tdata;
   logic [ReqUserBits-1:0]  req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_data;

   // mirror of the engine state
   logic [31:0] frame_mem [FrameCols*FrameRows];
   bit          frame_seen [FrameCols*FrameRows];
   logic [15:0] tap_mem [TapSlots];
   bit          tap_seen [TapSlots];
   logic [8:0]  img_w_reg;
   logic [8:0]  img_h_reg;
   logic [2:0]  kern_w_reg;
   logic [2:0]  kern_h_reg;
   logic [2:0]  lane_reg;

   logic [31:0]   pending_px [$];
   logic [31:0]   due_px;
   directed_row_t directed_rows [$];

   int send_pct;
   int recv_pct;
   int hold_left;
   int cycle_count;
   int error_count;
   int item_count;
   int request_count;
   int checked_count;
   int setting_count;

   image_convolution_clamped_border dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // register value brought into its legal range
   function automatic int fit_range(input int v, input int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   // replicate border: coordinate pinned to the image
   function automatic int edge_clamp(input int v, input int size);
      return (v < 0) ? 0 : ((v >= size) ? size - 1 : v);
   endfunction

   function automatic void geometry(output int w, output int h, output int kw,
                                    output int kh, output int lanes);
      w     = fit_range(img_w_reg, FrameCols);
      h     = fit_range(img_h_reg, FrameRows);
      kw    = fit_range(kern_w_reg, KernMax);
      kh    = fit_range(kern_h_reg, KernMax);
      lanes = fit_range(lane_reg, Lanes);
   endfunction

   // true when every pixel and weight the window touches has been written
   function automatic bit window_ready(input logic [7:0] col, input logic [7:0] row);
      int w, h, kw, kh, lanes, x, y;
      geometry(w, h, kw, kh, lanes);
      for (int ky = 0; ky < kh; ky++) begin
         y = edge_clamp(int'(row) - kh / 2 + ky, h);
         for (int kx = 0; kx < kw; kx++) begin
            x = edge_clamp(int'(col) - kw / 2 + kx, w);
            if (!frame_seen[y * FrameCols + x] || !tap_seen[ky * kw + kx]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // filtered pixel: exact weighted sum, then truncate and saturate per channel
   function automatic logic [31:0] filter_at(input logic [7:0] col, input logic [7:0] row);
      int w, h, kw, kh, lanes, x, y;
      longint acc [4];
      longint q;
      logic [31:0] word;
      logic [31:0] px;
      geometry(w, h, kw, kh, lanes);
      px = '0;
      for (int c = 0; c < 4; c++) acc[c] = 0;
      for (int ky = 0; ky < kh; ky++) begin
         y = edge_clamp(int'(row) - kh / 2 + ky, h);
         for (int kx = 0; kx < kw; kx++) begin
            x = edge_clamp(int'(col) - kw / 2 + kx, w);
            word = frame_mem[y * FrameCols + x];
            for (int c = 0; c < lanes; c++)
               acc[c] += longint'($signed(tap_mem[ky * kw + kx])) * longint'(word[8*c +: 8]);
         end
      end
      for (int c = 0; c < lanes; c++) begin
         if (acc[c] > 0) begin
            q = acc[c] >>> FracBits;
            if (q > 255) q = 255;
            px[8*c +: 8] = q[7:0];
         end
      end
      return px;
   endfunction

   // update the mirror for an accepted item and queue what it should produce
   task automatic take_item(input conv_item_t it, input bit known, input logic [31:0] known_px);
      case (it.op)
         OpLoadWeight: begin
            // taps past the 7x7 store are dropped
            if (it.tap < TapSlots) begin
               tap_mem[it.tap] = it.weight;
               tap_seen[it.tap] = 1'b1;
            end
         end
         OpWritePixel: begin
            // 8-bit coordinates always land inside the store
            frame_mem[{it.row, it.col}] = it.samples;
            frame_seen[{it.row, it.col}] = 1'b1;
         end
         OpCompute: begin
            pending_px.push_back(known ? known_px : filter_at(it.col, it.row));
            request_count++;
         end
         default: ;
      endcase
      item_count++;
   endtask

   // offer one item with a random gap in front; entered and left at a falling edge
   task automatic send_item(input conv_item_t it, input bit known, input logic [31:0] known_px);
      while (send_pct > 0 && $urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {2'b00, it.samples, it.weight, it.tap, it.row, it.col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      take_item(it, known, known_px);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CsrImageWidth:   img_w_reg  = val;
         CsrImageHeight:  img_h_reg  = val;
         CsrKernelWidth:  kern_w_reg = val[2:0];
         CsrKernelHeight: kern_h_reg = val[2:0];
         CsrChannelCount: lane_reg   = val[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every result, then let trailing loads and writes settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_px.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // weight scaled so that the kernel gain stays near one most of the time
   function automatic logic [15:0] pick_weight();
      int w, h, kw, kh, lanes, span;
      geometry(w, h, kw, kh, lanes);
      span = 8192 / (kw * kh);
      case ($urandom_range(19))
         0, 1, 2: return 16'($urandom);
         3, 4, 5, 6, 7: return 16'(int'($urandom_range(0, span + span / 2)) - span / 2);
         default: return 16'($urandom_range(0, span));
      endcase
   endfunction

   // random item shaped by the current setting; requests only read written entries
   function automatic conv_item_t draw_item();
      conv_item_t it;
      int w, h, kw, kh, lanes, pick, lim_w, lim_h, side;
      geometry(w, h, kw, kh, lanes);
      lim_w = (w < PrimeSpan) ? w : PrimeSpan;
      lim_h = (h < PrimeSpan) ? h : PrimeSpan;
      it.col     = 8'($urandom);
      it.row     = 8'($urandom);
      it.tap     = 6'($urandom);
      it.weight  = 16'($urandom);
      it.samples = $urandom;
      pick = $urandom_range(99);
      if (pick < 45) begin
         it.op = OpCompute;
         for (int tries = 0; tries < 8; tries++) begin
            case ($urandom_range(3))
               0: begin
                  it.col = 8'($urandom_range(0, w - 1));
                  it.row = 8'($urandom_range(0, h - 1));
               end
               1: begin
                  side = $urandom_range(1);
                  it.col = 8'(side ? 255 - $urandom_range(3) : $urandom_range(3));
                  it.row = 8'(side ? 255 - $urandom_range(3) : $urandom_range(3));
               end
               2: begin
                  it.col = 8'($urandom_range(1) ? w - 1 : 0);
                  it.row = 8'($urandom_range(1) ? h - 1 : 255);
               end
               default: begin
                  it.col = 8'($urandom);
                  it.row = 8'($urandom);
               end
            endcase
            if (window_ready(it.col, it.row)) return it;
         end
         // the top-left corner is always primed
         it.col = '0;
         it.row = '0;
      end else if (pick < 70) begin
         it.op = OpWritePixel;
         if ($urandom_range(9) < 6) begin
            it.col = 8'($urandom_range(0, lim_w - 1));
            it.row = 8'($urandom_range(0, lim_h - 1));
         end
      end else if (pick < 90) begin
         it.op = OpLoadWeight;
         it.tap = 6'($urandom_range(0, kw * kh - 1));
         it.weight = pick_weight();
      end else if (pick < 95) begin
         it.op = OpIgnored;
      end else begin
         // weight index past the store
         it.op = OpLoadWeight;
         it.tap = 6'($urandom_range(TapSlots, 63));
      end
      return it;
   endfunction

   function automatic directed_row_t dir_row(input logic [1:0] op, input logic [7:0] col,
                                             input logic [7:0] row, input logic [5:0] tap,
                                             input logic [15:0] weight,
                                             input logic [31:0] samples, input bit known,
                                             input logic [31:0] known_px);
      directed_row_t r;
      r.item.op      = op;
      r.item.col     = col;
      r.item.row     = row;
      r.item.tap     = tap;
      r.item.weight  = weight;
      r.item.samples = samples;
      r.known        = known;
      r.known_px     = known_px;
      return r;
   endfunction

   task automatic run_phase(input logic [8:0] width, input logic [8:0] height,
                            input logic [8:0] kw, input logic [8:0] kh,
                            input logic [8:0] lanes, input idle_mode_e mode,
                            input bit squeeze, input bit prime);
      conv_item_t it;
      write_reg(CsrImageWidth, width);
      write_reg(CsrImageHeight, height);
      write_reg(CsrKernelWidth, kw);
      write_reg(CsrKernelHeight, kh);
      write_reg(CsrChannelCount, lanes);
      for (int i = CsrFirstSpare; i < (1 << CsrIndexBits); i++)
         write_reg(3'(i), 9'($urandom));
      setting_count++;
      send_pct = (mode == IdleSender) ? IdlePct : ((mode == IdleBoth) ? BothPct : 0);
      recv_pct = (mode == IdleReceiver) ? IdlePct : ((mode == IdleBoth) ? BothPct : 0);

      // fill every weight and the two opposite corners of the frame
      if (prime) begin
         for (int t = 0; t < TapSlots; t++) begin
            it.op = OpLoadWeight;
            it.tap = 6'(t);
            it.weight = pick_weight();
            it.col = 8'($urandom);
            it.row = 8'($urandom);
            it.samples = $urandom;
            send_item(it, 1'b0, '0);
         end
         for (int r = 0; r < PrimeSpan; r++) begin
            for (int c = 0; c < PrimeSpan; c++) begin
               it.op = OpWritePixel;
               it.tap = 6'($urandom);
               it.weight = 16'($urandom);
               it.col = 8'(c);
               it.row = 8'(r);
               it.samples = $urandom;
               send_item(it, 1'b0, '0);
               it.col = 8'(FrameCols - 1 - c);
               it.row = 8'(FrameRows - 1 - r);
               it.samples = $urandom;
               send_item(it, 1'b0, '0);
            end
         end
      end

      // hold the result side off so that the engine backs up into its input
      if (squeeze) begin
         @(posedge clock);
         hold_left = HoldCycles;
         @(negedge clock);
      end

      for (int n = 0; n < ItemsPerPhase; n++) begin
         it = draw_item();
         send_item(it, 1'b0, '0);
      end
      drain();
   endtask

   // result side: random stalls, long hold when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_pct);
         end
      end
   end

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_px.size() == 0) begin
            $error("result item with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            due_px = pending_px.pop_front();
            checked_count++;
            for (int c = 0; c < Lanes; c++) begin
               if (rsp_tdata[8*c +: 8] !== due_px[8*c +: 8]) begin
                  $error("result_ch%0d expected %0d actual %0d", c, due_px[8*c +: 8],
                         rsp_tdata[8*c +: 8]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OpLoadWeight;
      csr_valid  = 1'b0;
      csr_index  = CsrImageWidth;
      csr_data   = '0;
      send_pct   = 0;
      recv_pct   = 0;
      hold_left  = 0;
      img_w_reg  = 9'd256;
      img_h_reg  = 9'd256;
      kern_w_reg = 3'd3;
      kern_h_reg = 3'd3;
      lane_reg   = 3'd1;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on a 1x1 image with a 1x1 kernel: every window is pixel (0,0)
      write_reg(CsrImageWidth, 9'd1);
      write_reg(CsrImageHeight, 9'd1);
      write_reg(CsrKernelWidth, 9'd1);
      write_reg(CsrKernelHeight, 9'd1);
      write_reg(CsrChannelCount, 9'd4);
      setting_count++;

      // unity weight passes the samples through
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'h1000, '0, 0, '0));
      directed_rows.push_back(dir_row(OpWritePixel, 8'd0, 8'd0, 6'd0, 16'h0, 32'h000180FF,
                                      0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd0, 8'd0, 6'd0, 16'h0, '0,
                                      1, 32'h000180FF));
      // request far outside the image clamps back onto it
      directed_rows.push_back(dir_row(OpCompute, 8'd255, 8'd255, 6'd0, 16'h0, '0,
                                      1, 32'h000180FF));
      // largest weight saturates high
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'h7FFF, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd0, 8'd128, 6'd0, 16'h0, '0,
                                      1, 32'h0007FFFF));
      // most negative and minus one lsb give zero
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'h8000, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd17, 8'd0, 6'd0, 16'h0, '0, 1, '0));
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'hFFFF, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd0, 8'd0, 6'd0, 16'h0, '0, 1, '0));
      // one lsb truncates to zero
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'h0001, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd0, 8'd0, 6'd0, 16'h0, '0, 1, '0));
      // one half: 255 truncates to 127
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'h0800, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd128, 8'd64, 6'd0, 16'h0, '0,
                                      1, 32'h0000407F));
      // taps past the store and the unknown op leave everything alone
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd63, 16'h7FFF, '0, 0, '0));
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd49, 16'h8000, '0, 0, '0));
      directed_rows.push_back(dir_row(OpIgnored, 8'd255, 8'd255, 6'd63, 16'hFFFF,
                                      32'hFFFFFFFF, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd0, 8'd0, 6'd0, 16'h0, '0,
                                      1, 32'h0000407F));
      // far corner of the store does not alias onto the image
      directed_rows.push_back(dir_row(OpWritePixel, 8'd255, 8'd255, 6'd0, 16'h0,
                                      32'hFFFFFFFF, 0, '0));
      directed_rows.push_back(dir_row(OpWritePixel, 8'd0, 8'd0, 6'd0, 16'h0,
                                      32'hFFFFFFFF, 0, '0));
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd48, 16'h1000, '0, 0, '0));
      directed_rows.push_back(dir_row(OpLoadWeight, 8'd0, 8'd0, 6'd0, 16'h1000, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd255, 8'd0, 6'd0, 16'h0, '0,
                                      1, 32'hFFFFFFFF));
      directed_rows.push_back(dir_row(OpWritePixel, 8'd0, 8'd0, 6'd0, 16'h0, '0, 0, '0));
      directed_rows.push_back(dir_row(OpCompute, 8'd0, 8'd0, 6'd0, 16'h0, '0, 1, '0));

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].known_px);
      drain();

      // random phases over several settings, extremes and out-of-range values included
      run_phase(9'd8, 9'd8, 9'd3, 9'd3, 9'd1, IdleNone, 1'b0, 1'b1);
      run_phase(9'd256, 9'd256, 9'd7, 9'd7, 9'd4, IdleSender, 1'b0, 1'b0);
      run_phase(9'd1, 9'd5, 9'd1, 9'd7, 9'd2, IdleReceiver, 1'b0, 1'b0);
      run_phase(9'd511, 9'd0, 9'd0, 9'd5, 9'd0, IdleBoth, 1'b0, 1'b0);
      run_phase(9'd5, 9'd7, 9'h10F, 9'd2, 9'd7, IdleNone, 1'b1, 1'b0);
      run_phase(9'd3, 9'd3, 9'd5, 9'd3, 9'd3, IdleBoth, 1'b1, 1'b0);

      if (pending_px.size() != 0) begin
         $error("%0d filtered pixels never arrived", pending_px.size());
         error_count++;
      end
      $display("sent %0d items (%0d filter requests) across %0d register settings",
               item_count, request_count, setting_count);
      $display("compared %0d filtered pixels, %0d field errors", checked_count, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
